FILE: src/bsis_pkg.sv
// ----------------------------------------------------------------------------
// bsis_pkg
// Shared types and constants for the background scan interval scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package bsis_pkg;

    // Field widths
    localparam int unsigned SecsW  = 16;
    localparam int unsigned FuncW  = 3;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDataW = 16;
    localparam int unsigned InDataW  = 8;   // func, trigger_ok, above, zero fill
    localparam int unsigned OutDataW = 8;   // scan_request, long_mode, zero fill

    // Interval used when a register holds zero
    localparam logic [SecsW-1:0] DEFAULT_INTERVAL = 16'd30;
    // Seconds since last scan above which a drop in short mode rescans
    localparam logic [SecsW-1:0] DROP_RESCAN_SECS = 16'd10;
    localparam logic [SecsW-1:0] SECS_MAX         = 16'hFFFF;

    // Register reset values
    localparam logic [SecsW-1:0] RST_SHORT_INTERVAL = 16'd30;
    localparam logic [SecsW-1:0] RST_LONG_INTERVAL  = 16'd30;
    localparam logic [SecsW-1:0] RST_MAX_SHORT      = 16'd2;

    // Item function codes
    typedef enum logic [FuncW-1:0] {
        FN_TICK    = 3'd0,
        FN_TRIGGER = 3'd1,
        FN_DONE    = 3'd2,
        FN_SIGNAL  = 3'd3,
        FN_START   = 3'd4
    } t_func;

    // Configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        CFG_SHORT_INTERVAL = 3'd0,
        CFG_LONG_INTERVAL  = 3'd1,
        CFG_MAX_SHORT      = 3'd2,
        CFG_THRESH_EN      = 3'd3,
        CFG_START_LONG     = 3'd4
    } t_cfg_idx;

    // One input item
    typedef struct packed {
        logic       above;
        logic       trigger_ok;
        logic [FuncW-1:0] func;
    } t_item;

    // One result item
    typedef struct packed {
        logic long_mode;
        logic scan_request;
    } t_result;

endpackage : bsis_pkg

`default_nettype wire

FILE: src/bsis_core.sv
// ----------------------------------------------------------------------------
// bsis_core
// Configuration registers, scheduler state and the per-item decision logic.
// The result is combinational from the item and the current state; state
// advances at the edge where i_fire is high.
// ----------------------------------------------------------------------------
`default_nettype none

module bsis_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [bsis_pkg::CfgIdxW-1:0]  i_cfg_addr,
    input  wire logic [bsis_pkg::CfgDataW-1:0] i_cfg_wdata,
    input  wire logic                          i_fire,
    input  wire bsis_pkg::t_item               i_item,
    output      bsis_pkg::t_result             o_result
);
    import bsis_pkg::*;

    // Configuration
    logic [SecsW-1:0] r_short_interval;
    logic [SecsW-1:0] r_long_interval;
    logic [SecsW-1:0] r_max_short;
    logic             r_thresh_en;
    logic             r_start_long;

    // Scheduler state
    logic             r_mode_long,   n_mode_long;
    logic [SecsW-1:0] r_short_count, n_short_count;
    logic [SecsW-1:0] r_secs,        n_secs;
    logic             r_timer_armed, n_timer_armed;
    logic [SecsW-1:0] r_timer_left,  n_timer_left;
    logic             n_scan;

    // Derived values
    logic [SecsW-1:0] eff_short;
    logic [SecsW-1:0] eff_long;
    logic [SecsW-1:0] cur_interval;
    logic [SecsW-1:0] inc_count;
    logic [SecsW:0]   secs_plus_short;
    logic             intervals_eq;
    logic             in_short_mode;

    assign eff_short       = (r_short_interval == '0) ? DEFAULT_INTERVAL : r_short_interval;
    assign eff_long        = (r_long_interval == '0) ? DEFAULT_INTERVAL : r_long_interval;
    assign intervals_eq    = (eff_short == eff_long);
    assign in_short_mode   = !r_mode_long || intervals_eq;
    assign cur_interval    = r_mode_long ? eff_long : eff_short;
    assign inc_count       = (r_short_count == SECS_MAX) ? r_short_count
                                                         : r_short_count + 1'b1;
    assign secs_plus_short = {1'b0, r_secs} + {1'b0, eff_short};

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_interval <= RST_SHORT_INTERVAL;
            r_long_interval  <= RST_LONG_INTERVAL;
            r_max_short      <= RST_MAX_SHORT;
            r_thresh_en      <= 1'b0;
            r_start_long     <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_SHORT_INTERVAL: r_short_interval <= i_cfg_wdata;
                CFG_LONG_INTERVAL:  r_long_interval  <= i_cfg_wdata;
                CFG_MAX_SHORT:      r_max_short      <= i_cfg_wdata;
                CFG_THRESH_EN:      r_thresh_en      <= i_cfg_wdata[0];
                CFG_START_LONG:     r_start_long     <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Next state and scan decision for the current item
    always_comb begin
        n_mode_long   = r_mode_long;
        n_short_count = r_short_count;
        n_secs        = r_secs;
        n_timer_armed = r_timer_armed;
        n_timer_left  = r_timer_left;
        n_scan        = 1'b0;
        case (t_func'(i_item.func))
            FN_TICK: begin
                if (r_secs != SECS_MAX) begin
                    n_secs = r_secs + 1'b1;
                end
                if (r_timer_armed) begin
                    if (r_timer_left <= 16'd1) begin
                        n_timer_armed = 1'b0;
                        n_timer_left  = '0;
                        n_scan        = 1'b1;
                    end else begin
                        n_timer_left = r_timer_left - 1'b1;
                    end
                end
            end
            FN_TRIGGER: begin
                if (!i_item.trigger_ok) begin
                    n_timer_armed = 1'b1;
                    n_timer_left  = cur_interval;
                end else begin
                    if (in_short_mode) begin
                        n_short_count = inc_count;
                        if (inc_count > r_max_short) begin
                            n_mode_long = 1'b1;
                        end
                    end else if (r_short_count != '0) begin
                        n_short_count = r_short_count - 1'b1;
                    end
                    n_secs = '0;
                end
            end
            FN_DONE: begin
                n_timer_armed = 1'b1;
                n_timer_left  = cur_interval;
            end
            FN_SIGNAL: begin
                if (!intervals_eq && r_thresh_en) begin
                    if (r_mode_long && !i_item.above) begin
                        // signal drop while long: go short, maybe scan now
                        n_mode_long = 1'b0;
                        if (r_secs > 16'd1 && r_short_count <= r_max_short) begin
                            n_scan = 1'b1;
                        end else if ({1'b0, eff_long} > secs_plus_short) begin
                            n_timer_armed = 1'b1;
                            n_timer_left  = eff_short;
                        end
                    end else if (!r_mode_long && i_item.above) begin
                        n_mode_long   = 1'b1;
                        n_timer_armed = 1'b1;
                        n_timer_left  = eff_long;
                    end else if (!i_item.above) begin
                        n_scan = (r_secs > DROP_RESCAN_SECS);
                    end
                    if (n_scan) begin
                        n_timer_armed = 1'b0;
                        n_timer_left  = '0;
                    end
                end
            end
            FN_START: begin
                n_mode_long   = r_thresh_en && r_start_long;
                n_short_count = '0;
                n_secs        = '0;
                n_timer_armed = 1'b1;
                n_timer_left  = (r_thresh_en && r_start_long) ? eff_long : eff_short;
            end
            default: ;
        endcase
    end

    // State update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_long   <= 1'b0;
            r_short_count <= '0;
            r_secs        <= '0;
            r_timer_armed <= 1'b0;
            r_timer_left  <= '0;
        end else if (i_fire) begin
            r_mode_long   <= n_mode_long;
            r_short_count <= n_short_count;
            r_secs        <= n_secs;
            r_timer_armed <= n_timer_armed;
            r_timer_left  <= n_timer_left;
        end
    end

    assign o_result.scan_request = n_scan;
    assign o_result.long_mode    = n_mode_long;

    // Intervals never read as zero, so an armed timer always has time left
    a_armed_left : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_timer_armed == (r_timer_left != '0))
        else $error("timer armed flag and count disagree");

    a_start_state : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_item.func == FN_START |=>
            r_timer_armed && r_secs == '0 && r_short_count == '0)
        else $error("start did not reset scheduler state");

    a_scan_disarms : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && n_scan |=> !r_timer_armed)
        else $error("scan request left timer armed");

endmodule : bsis_core

`default_nettype wire

FILE: src/background_scan_interval_scheduler_top.sv
// ----------------------------------------------------------------------------
// background_scan_interval_scheduler_top
// Background scan scheduler with stream input and output and a plain
// configuration write port.
// ----------------------------------------------------------------------------
// Pipeline: 2 register stages; an accepted item waits in the input register
//   and moves to the result register once that register is empty or taken.
// Throughput: one item per cycle unless the output is held; while a result
//   waits, the input register can still take one item, then input stalls.
// Reset: synchronous active low; config returns to defaults, state clears,
//   both stages empty.
`default_nettype none

module background_scan_interval_scheduler_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Configuration write port
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [bsis_pkg::CfgIdxW-1:0]  i_cfg_addr,
    input  wire logic [bsis_pkg::CfgDataW-1:0] i_cfg_wdata,
    // Input items
    input  wire logic                          i_s_axis_tvalid,
    output      logic                          o_s_axis_tready,
    // [2:0] func, [3] trigger_ok, [4] above, [7:5] zero
    input  wire logic [bsis_pkg::InDataW-1:0]  i_s_axis_tdata,
    // Result items
    output      logic                          o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    // [0] scan_request, [1] long_mode, [7:2] zero
    output      logic [bsis_pkg::OutDataW-1:0] o_m_axis_tdata
);
    import bsis_pkg::*;

    logic    r_in_valid;
    t_item   r_in_item;
    logic    r_out_valid;
    t_result r_out_result;
    t_result core_result;
    logic    proc;

    // Item moves from input register to result register when output frees
    assign proc            = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || proc;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_item <= t_item'(i_s_axis_tdata[$bits(t_item)-1:0]);
        end
    end

    bsis_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_fire      (proc),
        .i_item      (r_in_item),
        .o_result    (core_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc) begin
            r_out_result <= core_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OutDataW - $bits(t_result)){1'b0}}, r_out_result};

    // Input side stalls only when both stages are full and output is held
    a_stall_cause : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> r_in_valid && r_out_valid && !i_m_axis_tready)
        else $error("input stalled without a full pipeline");

    a_proc_loads : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc |=> r_out_valid)
        else $error("processed item did not reach result register");

    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !r_in_valid && !r_out_valid)
        else $error("pipeline not empty after reset");

endmodule : background_scan_interval_scheduler_top

`default_nettype wire

FILE: tb/sv/background_scan_interval_scheduler_top_test.sv
// ----------------------------------------------------------------------------
// background_scan_interval_scheduler_top_test
// Self-checking bench for the background scan scheduler. Items go in on
// the slave stream and results come back on the master stream, both with
// random idling. A behavioral scheduler in the bench tracks mode, short
// scan budget, seconds since scan and the countdown timer, and each result
// is compared with the oldest prediction. A directed plan runs first, then
// a short run at near-widest register values, then random phases under
// several register sets.
// ----------------------------------------------------------------------------
module background_scan_interval_scheduler_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    import bsis_pkg::*;

    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int PLAN_LEN      = 29;
    localparam int RAND_PHASES   = 6;
    localparam int PHASE_ITEMS   = 100;
    localparam int BURST_LEN     = 8;
    localparam int DRAIN_CYCLES  = 8;

    // Directed plan rows: either a register write or one item
    typedef enum logic {ROW_CFG, ROW_ITEM} t_row_kind;

    typedef struct packed {
        t_row_kind            kind;
        t_func                func;
        logic                 ok;
        logic                 above;
        t_cfg_idx             reg_idx;
        logic [CfgDataW-1:0]  value;
        logic                 typed;
        logic                 want_scan;
        logic                 want_long;
    } t_plan_row;

    // Clock, reset and DUT ports
    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_cfg_wr_en     = 1'b0;
    logic [CfgIdxW-1:0]   i_cfg_addr      = '0;
    logic [CfgDataW-1:0]  i_cfg_wdata     = '0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    // [2:0] func, [3] trigger_ok, [4] above, [7:5] zero
    logic [InDataW-1:0]   i_s_axis_tdata  = '0;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    // [0] scan_request, [1] long_mode, [7:2] zero
    logic [OutDataW-1:0]  o_m_axis_tdata;

    // Register copies for prediction
    logic [SecsW-1:0] cfg_short_iv  = RST_SHORT_INTERVAL;
    logic [SecsW-1:0] cfg_long_iv   = RST_LONG_INTERVAL;
    logic [SecsW-1:0] cfg_max_short = RST_MAX_SHORT;
    logic             cfg_thresh_en = 1'b0;
    logic             cfg_start_long = 1'b0;

    // Scheduler state for prediction
    logic             st_long   = 1'b0;
    logic [SecsW-1:0] st_shorts = '0;
    logic [SecsW-1:0] st_secs   = '0;
    logic             st_armed  = 1'b0;
    logic [SecsW-1:0] st_left   = '0;

    t_result    decision_q [$];
    int         mismatch_count = 0;
    int         results_seen   = 0;
    int         cycle_count    = 0;
    int         rx_hold        = 0;
    bit         calm           = 1'b0;
    bit         last_scan      = 1'b0;
    t_plan_row  dir_plan [PLAN_LEN];

    background_scan_interval_scheduler_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("background_scan_interval_scheduler_top regression: fail");
            $finish;
        end
    end

    // Mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Behavioral scheduler: advances the state by one item, gives the result
    function automatic t_result predict_scan_decision(input t_item it);
        t_result          res;
        logic [SecsW-1:0] iv_s;
        logic [SecsW-1:0] iv_l;
        logic [SecsW-1:0] iv_cur;
        logic             short_mode;
        logic             scan;
        iv_s       = (cfg_short_iv == '0) ? DEFAULT_INTERVAL : cfg_short_iv;
        iv_l       = (cfg_long_iv == '0) ? DEFAULT_INTERVAL : cfg_long_iv;
        short_mode = !st_long || (iv_s == iv_l);
        iv_cur     = st_long ? iv_l : iv_s;
        scan       = 1'b0;
        case (it.func)
            FN_TICK: begin
                if (st_secs != SECS_MAX) st_secs++;
                if (st_armed) begin
                    if (st_left <= 16'd1) begin
                        st_armed = 1'b0;
                        st_left  = '0;
                        scan     = 1'b1;
                    end else begin
                        st_left--;
                    end
                end
            end
            FN_TRIGGER: begin
                if (!it.trigger_ok) begin
                    st_armed = 1'b1;
                    st_left  = iv_cur;
                end else begin
                    // budget spent in short mode, earned back in long mode
                    if (short_mode) begin
                        if (st_shorts != SECS_MAX) st_shorts++;
                        if (st_shorts > cfg_max_short) st_long = 1'b1;
                    end else if (st_shorts != '0) begin
                        st_shorts--;
                    end
                    st_secs = '0;
                end
            end
            FN_DONE: begin
                st_armed = 1'b1;
                st_left  = iv_cur;
            end
            FN_SIGNAL: begin
                if (iv_s != iv_l && cfg_thresh_en) begin
                    if (st_long && !it.above) begin
                        st_long = 1'b0;
                        if (st_secs > 16'd1 && st_shorts <= cfg_max_short) begin
                            scan = 1'b1;
                        end else if ({1'b0, iv_l} > {1'b0, st_secs} + {1'b0, iv_s}) begin
                            st_armed = 1'b1;
                            st_left  = iv_s;
                        end
                    end else if (!st_long && it.above) begin
                        st_long  = 1'b1;
                        st_armed = 1'b1;
                        st_left  = iv_l;
                    end else if (!it.above) begin
                        if (st_secs > DROP_RESCAN_SECS) scan = 1'b1;
                    end
                    if (scan) begin
                        st_armed = 1'b0;
                        st_left  = '0;
                    end
                end
            end
            FN_START: begin
                st_long   = cfg_thresh_en && cfg_start_long;
                st_shorts = '0;
                st_secs   = '0;
                st_armed  = 1'b1;
                st_left   = st_long ? iv_l : iv_s;
            end
            default: ;
        endcase
        res.scan_request = scan;
        res.long_mode    = st_long;
        return res;
    endfunction

    function automatic t_item make_item(input t_func f, input logic ok, input logic up);
        t_item it;
        it.func       = f;
        it.trigger_ok = ok;
        it.above      = up;
        return it;
    endfunction

    // Plan row builders
    function automatic t_plan_row item_row(input t_func f, input logic ok, input logic up);
        return '{ROW_ITEM, f, ok, up, CFG_SHORT_INTERVAL, '0, 1'b0, 1'b0, 1'b0};
    endfunction

    function automatic t_plan_row typed_row(input t_func f, input logic ok, input logic up,
                                            input logic scan, input logic lng);
        return '{ROW_ITEM, f, ok, up, CFG_SHORT_INTERVAL, '0, 1'b1, scan, lng};
    endfunction

    function automatic t_plan_row cfg_row(input t_cfg_idx idx, input logic [CfgDataW-1:0] v);
        return '{ROW_CFG, FN_TICK, 1'b0, 1'b0, idx, v, 1'b0, 1'b0, 1'b0};
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("%0t result %0d: %s got %0h want %0h", $time, results_seen, what, got, want);
        mismatch_count++;
    endtask

    // Hold one item until accepted, predict it, then maybe idle
    task automatic send_item(input t_item it, input bit typed, input t_result typed_res);
        t_result res;
        int      n;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {3'b000, it};
        do @(posedge i_clk); while (!o_s_axis_tready);
        res       = predict_scan_decision(it);
        last_scan = res.scan_request;
        decision_q.push_back(typed ? typed_res : res);
        n = calm ? 0 : gap_len();
        if (n > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic send_burst(input t_item it, input int count);
        repeat (count) send_item(it, 1'b0, '0);
    endtask

    // Stop sending and let every outstanding result come back
    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        while (decision_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [CfgDataW-1:0] v);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_SHORT_INTERVAL: cfg_short_iv   = v;
            CFG_LONG_INTERVAL:  cfg_long_iv    = v;
            CFG_MAX_SHORT:      cfg_max_short  = v;
            CFG_THRESH_EN:      cfg_thresh_en  = v[0];
            CFG_START_LONG:     cfg_start_long = v[0];
            default: ;
        endcase
    endtask

    task automatic cfg_all(input logic [15:0] s, input logic [15:0] l, input logic [15:0] m,
                           input logic th, input logic sl);
        cfg_write(CFG_SHORT_INTERVAL, s);
        cfg_write(CFG_LONG_INTERVAL, l);
        cfg_write(CFG_MAX_SHORT, m);
        cfg_write(CFG_THRESH_EN, {15'd0, th});
        cfg_write(CFG_START_LONG, {15'd0, sl});
    endtask

    // Random item, weighted toward ticks and signal changes
    function automatic t_item rand_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return make_item(FN_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        if (r < 60)
            return make_item(FN_TRIGGER, $urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)));
        if (r < 70)
            return make_item(FN_DONE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        if (r < 95)
            return make_item(FN_SIGNAL, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        return make_item(FN_START, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endfunction

    // Result checker and receiver stalls
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = o_m_axis_tdata[1:0];
            results_seen++;
            if (decision_q.size() == 0) begin
                report_mismatch("unexpected result", o_m_axis_tdata, 8'h00);
            end else begin
                want = decision_q.pop_front();
                if (got.scan_request !== want.scan_request)
                    report_mismatch("scan_request", {7'd0, got.scan_request},
                                    {7'd0, want.scan_request});
                if (got.long_mode !== want.long_mode)
                    report_mismatch("long_mode", {7'd0, got.long_mode},
                                    {7'd0, want.long_mode});
                if (o_m_axis_tdata[7:2] !== 6'd0)
                    report_mismatch("zero fill", o_m_axis_tdata, {6'd0, want});
            end
        end
        if (rx_hold > 0) begin
            i_m_axis_tready <= 1'b0;
            rx_hold--;
        end else begin
            i_m_axis_tready <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0) rx_hold = gap_len();
        end
    end

    // Stimulus
    initial begin
        t_item it;
        t_item followups [$];
        int    sent;
        logic [15:0] s_iv;
        logic [15:0] l_iv;

        // After reset with default registers, then a short/long setup
        dir_plan = '{
            typed_row(FN_TICK,    1'b0, 1'b0, 1'b0, 1'b0),
            typed_row(FN_TRIGGER, 1'b0, 1'b0, 1'b0, 1'b0),
            typed_row(FN_SIGNAL,  1'b0, 1'b1, 1'b0, 1'b0),  // equal intervals: ignored
            typed_row(FN_DONE,    1'b0, 1'b0, 1'b0, 1'b0),
            typed_row(FN_START,   1'b0, 1'b0, 1'b0, 1'b0),
            cfg_row(CFG_SHORT_INTERVAL, 16'd2),
            cfg_row(CFG_LONG_INTERVAL,  16'd5),
            cfg_row(CFG_MAX_SHORT,      16'd1),
            cfg_row(CFG_THRESH_EN,      16'd1),
            typed_row(FN_START,   1'b0, 1'b0, 1'b0, 1'b0),
            item_row(FN_TICK,     1'b0, 1'b0),
            typed_row(FN_TICK,    1'b0, 1'b0, 1'b1, 1'b0),  // timer expires
            item_row(FN_TRIGGER,  1'b1, 1'b0),
            typed_row(FN_TRIGGER, 1'b1, 1'b0, 1'b0, 1'b1),  // budget spent: long
            item_row(FN_TRIGGER,  1'b0, 1'b0),
            item_row(FN_SIGNAL,   1'b0, 1'b1),
            item_row(FN_TICK,     1'b0, 1'b0),
            item_row(FN_TICK,     1'b0, 1'b0),
            item_row(FN_SIGNAL,   1'b0, 1'b0),              // drop, re-arm short
            item_row(FN_SIGNAL,   1'b0, 1'b0),              // drop in short mode
            item_row(FN_SIGNAL,   1'b0, 1'b1),              // rise: long
            item_row(FN_TRIGGER,  1'b1, 1'b0),              // earns one short scan
            item_row(FN_TICK,     1'b0, 1'b0),
            item_row(FN_TICK,     1'b0, 1'b0),
            item_row(FN_SIGNAL,   1'b0, 1'b0),              // drop with immediate scan
            item_row(FN_DONE,     1'b0, 1'b0),
            cfg_row(CFG_START_LONG,     16'd1),
            typed_row(FN_START,   1'b0, 1'b0, 1'b0, 1'b1),
            item_row(FN_TICK,     1'b0, 1'b0)
        };

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed plan
        foreach (dir_plan[k]) begin
            if (dir_plan[k].kind == ROW_CFG) begin
                wait_idle();
                cfg_write(dir_plan[k].reg_idx, dir_plan[k].value);
            end else begin
                send_item(make_item(dir_plan[k].func, dir_plan[k].ok, dir_plan[k].above),
                          dir_plan[k].typed, {dir_plan[k].want_long, dir_plan[k].want_scan});
            end
        end

        // Near-widest intervals and widest short scan budget
        wait_idle();
        calm = 1'b1;
        cfg_all(16'd65534, 16'd65535, 16'd65535, 1'b1, 1'b1);
        send_item(make_item(FN_START, 1'b0, 1'b0), 1'b0, '0);
        send_burst(make_item(FN_TICK, 1'b0, 1'b0), BURST_LEN);
        send_item(make_item(FN_SIGNAL, 1'b0, 1'b0), 1'b0, '0);
        send_burst(make_item(FN_TRIGGER, 1'b1, 1'b0), BURST_LEN);
        send_item(make_item(FN_SIGNAL, 1'b0, 1'b1), 1'b0, '0);
        send_item(make_item(FN_TRIGGER, 1'b1, 1'b0), 1'b0, '0);
        send_item(make_item(FN_DONE, 1'b0, 1'b0), 1'b0, '0);

        // Random phases, each under its own register set
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            wait_idle();
            calm = (ph == 3) || ($urandom_range(0, 3) == 0);
            case (ph)
                0: cfg_all(16'd1, 16'd65535, 16'd1, 1'b1, 1'b0);
                1: cfg_all(16'd65535, 16'd1, 16'd65535, 1'b1, 1'b1);
                default: begin
                    s_iv = 16'($urandom_range(1, 8));
                    l_iv = ($urandom_range(0, 4) == 0) ? s_iv : 16'($urandom_range(1, 12));
                    cfg_all(s_iv, l_iv, 16'($urandom_range(1, 3)),
                            $urandom_range(0, 4) != 0, 1'($urandom_range(0, 1)));
                end
            endcase
            sent = 0;
            followups.delete();
            if ($urandom_range(0, 9) != 0) begin
                send_item(make_item(FN_START, 1'($urandom_range(0, 1)),
                                    1'($urandom_range(0, 1))), 1'b0, '0);
                sent++;
            end
            while (sent < PHASE_ITEMS) begin
                // a requested scan is usually followed by its outcome and completion
                if (followups.size() != 0 && $urandom_range(0, 9) != 0)
                    it = followups.pop_front();
                else
                    it = rand_item();
                send_item(it, 1'b0, '0);
                sent++;
                if (last_scan && $urandom_range(0, 9) < 8) begin
                    followups.delete();
                    it = make_item(FN_TRIGGER, $urandom_range(0, 3) != 0,
                                   1'($urandom_range(0, 1)));
                    followups.push_back(it);
                    if (it.trigger_ok)
                        followups.push_back(make_item(FN_DONE, 1'b0,
                                                      1'($urandom_range(0, 1))));
                end
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && decision_q.size() == 0) begin
            $display("background_scan_interval_scheduler_top regression: pass");
        end else begin
            $display("background_scan_interval_scheduler_top regression: fail");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/bsis_pkg.sv
src/bsis_core.sv
src/background_scan_interval_scheduler_top.sv
tb/sv/background_scan_interval_scheduler_top_test.sv
